@@ rtl/dp_immediate_execute_defines.svh @@
`ifndef DP_IMMEDIATE_EXECUTE_DEFINES_SVH
`define DP_IMMEDIATE_EXECUTE_DEFINES_SVH

// check a property on every clock while out of reset
`define DPIE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition is followed by a property on the next clock
`define DPIE_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> prop) else $error(msg);

`endif

@@ rtl/dpie_pkg.sv @@
package dpie_pkg;

    localparam int NUM_REGS_DEF = 31;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [4:0] ZERO_REG = 5'd31;

    localparam logic KIND_ARITH = 1'b0;
    localparam logic KIND_MOVE  = 1'b1;

    localparam logic [1:0] OPC_MOVN  = 2'd0;
    localparam logic [1:0] OPC_UNDEF = 2'd1;
    localparam logic [1:0] OPC_MOVZ  = 2'd2;
    localparam logic [1:0] OPC_MOVK  = 2'd3;

    localparam int OPC_SET_FLAGS_BIT = 0;
    localparam int OPC_SUB_BIT       = 1;

    localparam logic [63:0] LANE_MASK = 64'h0000_0000_0000_FFFF;
    localparam logic [63:0] MASK32    = 64'h0000_0000_FFFF_FFFF;

    localparam logic [3:0] FLAGS_RESET = 4'b0100;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MOVN,
        OP_MOVZ,
        OP_MOVK,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        set_flags;
        logic        wide;
        logic [4:0]  read_reg;
        logic [4:0]  dest_reg;
        logic [1:0]  half_sel;
        logic [63:0] imm;
    } req_t;

    typedef struct packed {
        logic        write_enable;
        logic [4:0]  write_reg;
        logic [63:0] write_value;
        logic [3:0]  flags;
    } res_t;

endpackage

@@ rtl/dp_immediate_execute.sv @@
// A pushed request is registered in the request queue, executed from its head, and its result
// registered in the result queue. Throughput: one request per cycle while the result queue is
// not full; the execute step reads the register file and flags, updates them and retires in the
// same cycle, so back-to-back dependent requests see results. Reset (rst_n low, asynchronous):
// registers cleared to zero, flags set to Z only, both queues emptied.
module dp_immediate_execute
#(
    parameter int NUM_REGS = dpie_pkg::NUM_REGS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        kind,
    input  logic        wide,
    input  logic [1:0]  opc,
    input  logic        shift_twelve,
    input  logic [11:0] imm_twelve,
    input  logic [4:0]  src_reg,
    input  logic [1:0]  half_sel,
    input  logic [15:0] imm_sixteen,
    input  logic [4:0]  dest_reg,
    output logic        empty,
    input  logic        pop,
    output logic        write_enable,
    output logic [4:0]  write_reg,
    output logic [63:0] write_value,
    output logic        flag_n,
    output logic        flag_z,
    output logic        flag_c,
    output logic        flag_v
);
    import dpie_pkg::*;

    req_t dec_req;
    req_t exe_req;
    logic req_empty;
    logic exe_ready;
    logic exe_valid;
    res_t exe_res;
    logic res_full;
    res_t out_res;

    dpie_front u_front
    (
        .kind         (kind),
        .wide         (wide),
        .opc          (opc),
        .shift_twelve (shift_twelve),
        .imm_twelve   (imm_twelve),
        .src_reg      (src_reg),
        .half_sel     (half_sel),
        .imm_sixteen  (imm_sixteen),
        .dest_reg     (dest_reg),
        .req          (dec_req)
    );

    dpie_queue #(.T(req_t)) u_req_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (dec_req),
        .full  (full),
        .pop   (exe_ready),
        .rdata (exe_req),
        .empty (req_empty)
    );

    dpie_back #(.NUM_REGS(NUM_REGS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (!req_empty),
        .req       (exe_req),
        .req_ready (exe_ready),
        .res_valid (exe_valid),
        .res       (exe_res),
        .res_ready (!res_full)
    );

    dpie_queue #(.T(res_t)) u_res_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (exe_valid),
        .wdata (exe_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (out_res),
        .empty (empty)
    );

    assign write_enable = out_res.write_enable;
    assign write_reg    = out_res.write_reg;
    assign write_value  = out_res.write_value;
    assign flag_n       = out_res.flags[3];
    assign flag_z       = out_res.flags[2];
    assign flag_c       = out_res.flags[1];
    assign flag_v       = out_res.flags[0];

endmodule

@@ rtl/dpie_front.sv @@
module dpie_front
(
    input  logic            kind,
    input  logic            wide,
    input  logic [1:0]      opc,
    input  logic            shift_twelve,
    input  logic [11:0]     imm_twelve,
    input  logic [4:0]      src_reg,
    input  logic [1:0]      half_sel,
    input  logic [15:0]     imm_sixteen,
    input  logic [4:0]      dest_reg,
    output dpie_pkg::req_t  req
);
    import dpie_pkg::*;

    always_comb
    begin
        req           = '0;
        req.wide      = wide;
        req.dest_reg  = dest_reg;
        req.half_sel  = half_sel;
        req.set_flags = 1'b0;
        if (kind == KIND_ARITH)
        begin
            req.read_reg  = src_reg;
            req.set_flags = opc[OPC_SET_FLAGS_BIT];
            req.op        = opc[OPC_SUB_BIT] ? OP_SUB : OP_ADD;
            req.imm       = shift_twelve ? {40'd0, imm_twelve, 12'd0} : {52'd0, imm_twelve};
        end
        else
        begin
            req.read_reg = dest_reg;
            req.imm      = {48'd0, imm_sixteen} << {half_sel, 4'b0000};
            unique case (opc)
                OPC_MOVN:  req.op = OP_MOVN;
                OPC_MOVZ:  req.op = OP_MOVZ;
                OPC_MOVK:  req.op = OP_MOVK;
                OPC_UNDEF: req.op = OP_NONE;
                default:   req.op = OP_NONE;
            endcase
            // drop lanes above the operation width
            if (!wide && half_sel[1])
            begin
                req.op = OP_NONE;
            end
        end
    end

endmodule

@@ rtl/dpie_queue.sv @@
module dpie_queue
#(
    parameter type T = logic
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     wdata,
    output logic full,
    input  logic pop,
    output T     rdata,
    output logic empty
);
    import dpie_pkg::*;

    T                  entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    function automatic logic [QPTR_W-1:0] ptr_advance(input logic [QPTR_W-1:0] p);
        ptr_advance = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_advance(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_advance(rd_ptr_reg) : rd_ptr_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ rtl/dpie_back.sv @@
module dpie_back
#(
    parameter int NUM_REGS = dpie_pkg::NUM_REGS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  dpie_pkg::req_t  req,
    output logic            req_ready,
    output logic            res_valid,
    output dpie_pkg::res_t  res,
    input  logic            res_ready
);
    import dpie_pkg::*;

    localparam int         IDX_W     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam logic [4:0] REG_LIMIT = 5'(NUM_REGS);

    logic [63:0] regs_reg [NUM_REGS];
    logic [3:0]  flags_reg;
    logic [3:0]  flags_next;
    logic        fire;
    logic [63:0] rdata;
    logic [63:0] wmask;
    logic [63:0] a;
    logic [63:0] lane_mask;
    logic [64:0] b_ext;
    logic [64:0] sum;
    logic        is_sub;
    logic [63:0] result;
    logic        sa;
    logic        sb;
    logic        sr;
    logic        n;
    logic        z;
    logic        c;
    logic        v;
    logic        we;

    assign fire      = req_valid && res_ready;
    assign req_ready = res_ready;
    assign res_valid = req_valid;

    assign rdata = (req.read_reg < REG_LIMIT) ? regs_reg[req.read_reg[IDX_W-1:0]] : '0;

    always_comb
    begin
        wmask     = req.wide ? '1 : MASK32;
        a         = rdata & wmask;
        is_sub    = (req.op == OP_SUB);
        b_ext     = {1'b0, req.imm};
        sum       = {1'b0, a} + (is_sub ? ~b_ext : b_ext) + {64'd0, is_sub};
        lane_mask = LANE_MASK << {req.half_sel, 4'b0000};

        unique case (req.op)
            OP_ADD, OP_SUB: result = sum[63:0] & wmask;
            OP_MOVN:        result = ~req.imm & wmask;
            OP_MOVZ:        result = req.imm & wmask;
            OP_MOVK:        result = ((a & ~lane_mask) | req.imm) & wmask;
            default:        result = '0;
        endcase

        sa = req.wide ? a[63] : a[31];
        sb = req.wide ? req.imm[63] : req.imm[31];
        sr = req.wide ? result[63] : result[31];
        n  = sr;
        z  = (result == '0);
        c  = is_sub ? ~sum[64] : (req.wide ? sum[64] : sum[32]);
        v  = is_sub ? ((sa != sb) && (sr != sa)) : ((sa == sb) && (sr != sa));

        flags_next = flags_reg;
        if (fire && req.set_flags)
        begin
            flags_next = {n, z, c, v};
        end

        we = (req.op != OP_NONE) && (req.dest_reg < REG_LIMIT);

        res.write_enable = we;
        res.write_reg    = we ? req.dest_reg : '0;
        res.write_value  = we ? result : '0;
        res.flags        = flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= FLAGS_RESET;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else if (fire && we)
        begin
            regs_reg[req.dest_reg[IDX_W-1:0]] <= result;
        end
    end

endmodule

@@ rtl/dpie_checker.sv @@
`include "dp_immediate_execute_defines.svh"

module dpie_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic        write_enable,
    input logic [4:0]  write_reg,
    input logic [63:0] write_value,
    input logic        flag_n,
    input logic        flag_z,
    input logic        flag_c,
    input logic        flag_v
);
    import dpie_pkg::*;

    logic [73:0] out_bits;
    logic        write_clear;

    assign out_bits    = {write_enable, write_reg, write_value, flag_n, flag_z, flag_c, flag_v};
    assign write_clear = (write_reg == 5'd0) && (write_value == 64'd0);

    `DPIE_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_bits), "held result changed")
    `DPIE_ASSERT(a_clear, !empty && !write_enable |-> write_clear, "discarded write shows data")
    `DPIE_ASSERT(a_zero_reg, !empty && write_enable |-> write_reg != ZERO_REG, "zero register written")
    `DPIE_ASSERT(a_flow, push && !full |-> ##2 !empty, "accepted request produced no result")

endmodule

bind dp_immediate_execute dpie_checker u_checker (.*);

@@ test/dp_immediate_execute_test.sv @@
`timescale 1ns / 100ps

module dp_immediate_execute_test;
    import dpie_pkg::*;

    localparam logic [1:0] ARITH_ADD  = 2'd0;
    localparam logic [1:0] ARITH_ADDS = 2'd1;
    localparam logic [1:0] ARITH_SUB  = 2'd2;
    localparam logic [1:0] ARITH_SUBS = 2'd3;

    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] SIGN32 = 64'h0000_0000_8000_0000;

    typedef struct packed {
        logic        kind;
        logic        wide;
        logic [1:0]  opc;
        logic        shift_twelve;
        logic [11:0] imm_twelve;
        logic [4:0]  src_reg;
        logic [1:0]  half_sel;
        logic [15:0] imm_sixteen;
        logic [4:0]  dest_reg;
    } instr_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        kind;
    logic        wide;
    logic [1:0]  opc;
    logic        shift_twelve;
    logic [11:0] imm_twelve;
    logic [4:0]  src_reg;
    logic [1:0]  half_sel;
    logic [15:0] imm_sixteen;
    logic [4:0]  dest_reg;
    logic        empty;
    logic        pop;
    logic        write_enable;
    logic [4:0]  write_reg;
    logic [63:0] write_value;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;

    logic [63:0] model_regs [NUM_REGS_DEF];
    logic [3:0]  model_flags;
    res_t        writeback_queue [$];

    int error_count;
    int results_checked;
    int arith_count;
    int move_count;
    int discarded_count;
    int full_stall_cycles;

    bit tx_bursts_on;
    bit rx_bursts_on;
    int rx_hold_left;
    int rx_gap_left;

    dp_immediate_execute DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .wide         (wide),
        .opc          (opc),
        .shift_twelve (shift_twelve),
        .imm_twelve   (imm_twelve),
        .src_reg      (src_reg),
        .half_sel     (half_sel),
        .imm_sixteen  (imm_sixteen),
        .dest_reg     (dest_reg),
        .empty        (empty),
        .pop          (pop),
        .write_enable (write_enable),
        .write_reg    (write_reg),
        .write_value  (write_value),
        .flag_n       (flag_n),
        .flag_z       (flag_z),
        .flag_c       (flag_c),
        .flag_v       (flag_v)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [63:0] read_model_reg(logic [4:0] r);
        if (r == ZERO_REG || int'(r) >= NUM_REGS_DEF)
        begin
            return 64'd0;
        end
        return model_regs[r];
    endfunction

    // Retire one request against the model state and queue its writeback.
    task automatic execute_instr(input instr_t ins);
        logic [63:0] mask;
        logic [63:0] top;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] op;
        logic [63:0] res;
        logic        produce;
        logic        sub;
        logic        sa;
        logic        sb;
        logic        sr;
        logic        c;
        logic        v;
        int          sh;
        res_t        wb;
        mask = ins.wide ? '1 : MASK32;
        top = ins.wide ? SIGN64 : SIGN32;
        res = 64'd0;
        produce = 1'b0;
        if (ins.kind == KIND_ARITH)
        begin
            arith_count++;
            a = read_model_reg(ins.src_reg) & mask;
            b = ins.shift_twelve ? {40'd0, ins.imm_twelve, 12'd0} : {52'd0, ins.imm_twelve};
            sub = ins.opc[OPC_SUB_BIT];
            res = (sub ? a - b : a + b) & mask;
            produce = 1'b1;
            if (ins.opc[OPC_SET_FLAGS_BIT])
            begin
                sa = |(a & top);
                sb = |(b & top);
                sr = |(res & top);
                if (sub)
                begin
                    c = a >= b;
                    v = (sa != sb) && (sr != sa);
                end
                else
                begin
                    c = a > (mask - b);
                    v = (sa == sb) && (sr != sa);
                end
                model_flags = {sr, res == 64'd0, c, v};
            end
        end
        else
        begin
            move_count++;
            if (ins.opc != OPC_UNDEF && (ins.wide || ins.half_sel <= 2'd1))
            begin
                sh = int'(ins.half_sel) * 16;
                op = {48'd0, ins.imm_sixteen} << sh;
                produce = 1'b1;
                case (ins.opc)
                    OPC_MOVN: res = ~op & mask;
                    OPC_MOVZ: res = op & mask;
                    default:
                        res = ((read_model_reg(ins.dest_reg) & ~(LANE_MASK << sh)) | op) & mask;
                endcase
            end
        end
        wb.write_enable = 1'b0;
        wb.write_reg = 5'd0;
        wb.write_value = 64'd0;
        if (produce && ins.dest_reg != ZERO_REG && int'(ins.dest_reg) < NUM_REGS_DEF)
        begin
            model_regs[ins.dest_reg] = res;
            wb.write_enable = 1'b1;
            wb.write_reg = ins.dest_reg;
            wb.write_value = res;
        end
        else
        begin
            discarded_count++;
        end
        wb.flags = model_flags;
        writeback_queue.push_back(wb);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("%0t: MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && pop && !empty)
        begin
            if (writeback_queue.size() == 0)
            begin
                report_mismatch("result with no request pending", write_value, 64'd0);
            end
            else
            begin
                want = writeback_queue.pop_front();
                results_checked++;
                if (write_enable !== want.write_enable)
                    report_mismatch("write_enable", 64'(write_enable), 64'(want.write_enable));
                if (write_reg !== want.write_reg)
                    report_mismatch("write_reg", 64'(write_reg), 64'(want.write_reg));
                if (write_value !== want.write_value)
                    report_mismatch("write_value", write_value, want.write_value);
                if (flag_n !== want.flags[3])
                    report_mismatch("flag_n", 64'(flag_n), 64'(want.flags[3]));
                if (flag_z !== want.flags[2])
                    report_mismatch("flag_z", 64'(flag_z), 64'(want.flags[2]));
                if (flag_c !== want.flags[1])
                    report_mismatch("flag_c", 64'(flag_c), 64'(want.flags[1]));
                if (flag_v !== want.flags[0])
                    report_mismatch("flag_v", 64'(flag_v), 64'(want.flags[0]));
            end
        end
        if (rst_n && push && full)
        begin
            full_stall_cycles++;
        end
    end

    // Hold pop low for a long hold-off or a random burst, else pop.
    initial
    begin
        pop = 1'b0;
        rx_gap_left = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                pop = 1'b0;
                rx_hold_left--;
            end
            else if (rx_bursts_on && rx_gap_left > 0)
            begin
                pop = 1'b0;
                rx_gap_left--;
            end
            else if (rx_bursts_on && $urandom_range(0, 7) == 0)
            begin
                pop = 1'b0;
                rx_gap_left = $urandom_range(1, 19) - 1;
            end
            else
            begin
                pop = 1'b1;
            end
        end
    end

    task automatic send_instr(input instr_t ins);
        kind = ins.kind;
        wide = ins.wide;
        opc = ins.opc;
        shift_twelve = ins.shift_twelve;
        imm_twelve = ins.imm_twelve;
        src_reg = ins.src_reg;
        half_sel = ins.half_sel;
        imm_sixteen = ins.imm_sixteen;
        dest_reg = ins.dest_reg;
        push = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
        end
        execute_instr(ins);
        @(negedge clk);
    endtask

    task automatic sender_idle(input int cycles);
        push = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic wait_drain();
        push = 1'b0;
        while (writeback_queue.size() != 0)
            @(negedge clk);
    endtask

    function automatic instr_t make_arith(logic w, logic [1:0] op, logic sh,
                                          logic [11:0] imm, logic [4:0] src, logic [4:0] dst);
        instr_t ins;
        ins.kind = KIND_ARITH;
        ins.wide = w;
        ins.opc = op;
        ins.shift_twelve = sh;
        ins.imm_twelve = imm;
        ins.src_reg = src;
        ins.half_sel = 2'($urandom);
        ins.imm_sixteen = 16'($urandom);
        ins.dest_reg = dst;
        return ins;
    endfunction

    function automatic instr_t make_move(logic w, logic [1:0] op, logic [1:0] lane,
                                         logic [15:0] imm, logic [4:0] dst);
        instr_t ins;
        ins.kind = KIND_MOVE;
        ins.wide = w;
        ins.opc = op;
        ins.shift_twelve = 1'($urandom);
        ins.imm_twelve = 12'($urandom);
        ins.src_reg = 5'($urandom);
        ins.half_sel = lane;
        ins.imm_sixteen = imm;
        ins.dest_reg = dst;
        return ins;
    endfunction

    function automatic logic [4:0] pick_reg();
        case ($urandom_range(0, 9))
            0: return ZERO_REG;
            1: return 5'($urandom_range(0, 31));
            default: return 5'($urandom_range(0, 5));
        endcase
    endfunction

    function automatic instr_t random_instr();
        instr_t ins;
        ins.kind = 1'($urandom);
        ins.wide = 1'($urandom);
        ins.opc = 2'($urandom);
        ins.shift_twelve = 1'($urandom);
        case ($urandom_range(0, 5))
            0: ins.imm_twelve = 12'd0;
            1: ins.imm_twelve = 12'hfff;
            2: ins.imm_twelve = 12'd1;
            default: ins.imm_twelve = 12'($urandom);
        endcase
        ins.src_reg = pick_reg();
        ins.half_sel = 2'($urandom);
        if (!ins.wide && $urandom_range(0, 3) != 0)
            ins.half_sel[1] = 1'b0;
        case ($urandom_range(0, 7))
            0: ins.imm_sixteen = 16'h0000;
            1: ins.imm_sixteen = 16'hffff;
            2: ins.imm_sixteen = 16'h8000;
            3: ins.imm_sixteen = 16'h7fff;
            default: ins.imm_sixteen = 16'($urandom);
        endcase
        ins.dest_reg = pick_reg();
        return ins;
    endfunction

    task automatic test_arith_directed();
        send_instr(make_arith(1'b1, ARITH_ADDS, 1'b0, 12'd0, ZERO_REG, 5'd0));
        send_instr(make_arith(1'b1, ARITH_ADDS, 1'b1, 12'hfff, 5'd0, 5'd1));
        send_instr(make_arith(1'b0, ARITH_SUBS, 1'b0, 12'd1, ZERO_REG, 5'd2));
        send_instr(make_arith(1'b1, ARITH_SUBS, 1'b0, 12'hfff, ZERO_REG, 5'd3));
        send_instr(make_arith(1'b0, ARITH_ADD, 1'b0, 12'd1, 5'd2, 5'd4));
        send_instr(make_arith(1'b1, ARITH_SUB, 1'b1, 12'hfff, 5'd1, 5'd5));
        send_instr(make_arith(1'b0, ARITH_ADDS, 1'b0, 12'd1, 5'd2, ZERO_REG));
        send_instr(make_arith(1'b1, ARITH_SUBS, 1'b1, 12'hfff, 5'd3, 5'd30));
    endtask

    task automatic test_move_directed();
        send_instr(make_move(1'b1, OPC_MOVZ, 2'd3, 16'h7fff, 5'd6));
        send_instr(make_move(1'b1, OPC_MOVK, 2'd0, 16'hffff, 5'd6));
        send_instr(make_move(1'b1, OPC_MOVK, 2'd1, 16'hffff, 5'd6));
        send_instr(make_move(1'b1, OPC_MOVK, 2'd2, 16'hffff, 5'd6));
        send_instr(make_arith(1'b1, ARITH_ADDS, 1'b0, 12'd1, 5'd6, 5'd7));
        send_instr(make_move(1'b1, OPC_MOVN, 2'd0, 16'h0000, 5'd8));
        send_instr(make_arith(1'b1, ARITH_ADDS, 1'b0, 12'd1, 5'd8, 5'd9));
        send_instr(make_move(1'b0, OPC_MOVZ, 2'd1, 16'h8000, 5'd10));
        send_instr(make_arith(1'b0, ARITH_SUBS, 1'b0, 12'd1, 5'd10, 5'd11));
        send_instr(make_move(1'b0, OPC_MOVN, 2'd1, 16'hffff, 5'd12));
        send_instr(make_move(1'b0, OPC_MOVK, 2'd1, 16'h1234, 5'd8));
        send_instr(make_move(1'b1, OPC_UNDEF, 2'd0, 16'hffff, 5'd9));
        send_instr(make_move(1'b0, OPC_MOVZ, 2'd2, 16'hffff, 5'd9));
        send_instr(make_move(1'b0, OPC_MOVK, 2'd3, 16'hffff, 5'd9));
        send_instr(make_move(1'b1, OPC_MOVZ, 2'd3, 16'hffff, ZERO_REG));
    endtask

    // Stall the result side long enough to fill the block, then drain.
    task automatic test_backpressure();
        wait_drain();
        rx_hold_left = 80;
        repeat (30) send_instr(random_instr());
        wait_drain();
        sender_idle($urandom_range(1, 19));
    endtask

    task automatic test_random_traffic(input int count, input bit with_idles);
        tx_bursts_on = with_idles;
        rx_bursts_on = with_idles;
        repeat (count)
        begin
            if (tx_bursts_on && $urandom_range(0, 7) == 0)
                sender_idle($urandom_range(1, 19));
            send_instr(random_instr());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        kind = 1'b0;
        wide = 1'b0;
        opc = 2'd0;
        shift_twelve = 1'b0;
        imm_twelve = 12'd0;
        src_reg = 5'd0;
        half_sel = 2'd0;
        imm_sixteen = 16'd0;
        dest_reg = 5'd0;
        tx_bursts_on = 1'b0;
        rx_bursts_on = 1'b0;
        rx_hold_left = 0;
        error_count = 0;
        results_checked = 0;
        arith_count = 0;
        move_count = 0;
        discarded_count = 0;
        full_stall_cycles = 0;
        for (int i = 0; i < NUM_REGS_DEF; i++)
            model_regs[i] = 64'd0;
        model_flags = FLAGS_RESET;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_arith_directed();
        test_move_directed();
        test_backpressure();
        test_random_traffic(800, 1'b1);
        test_backpressure();
        test_random_traffic(700, 1'b1);
        test_random_traffic(200, 1'b0);

        wait_drain();
        repeat (10) @(negedge clk);
        if (writeback_queue.size() != 0)
            report_mismatch("results never returned", 64'(writeback_queue.size()), 64'd0);
        $display("Ran %0d arithmetic and %0d wide-move requests, %0d writes discarded,",
                 arith_count, move_count, discarded_count);
        $display("checked %0d results; input stalled on full for %0d cycles",
                 results_checked, full_stall_cycles);
        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/dpie_pkg.sv
rtl/dpie_front.sv
rtl/dpie_queue.sv
rtl/dpie_back.sv
rtl/dp_immediate_execute.sv
rtl/dpie_checker.sv
test/dp_immediate_execute_test.sv
